@@ design/spq_pkg.sv @@
package spq_pkg;

  // queue capacity and stored payload width
  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 16;

  // field widths of the channels
  localparam int CMD_W   = 2;
  localparam int PRIO_W  = 3;
  localparam int PAYIN_W = 16;
  localparam int STAT_W  = 2;

  // derived widths
  localparam int PAY_W  = (PAYLOAD_BITS < PAYIN_W) ? PAYLOAD_BITS : PAYIN_W;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = PRIO_W + PAY_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_CMP,
    S_REM,
    S_DONE
  } state_t;

endpackage

@@ design/stable_priority_queue.sv @@
// Stable priority queue, sorted by ascending priority number.
// Input channel: in_valid / in_stall with command, priority_req, payload.
// A beat is taken when in_valid is high and in_stall is low. Insert puts the
// entry behind every stored entry of equal or lower number, remove returns
// the head entry, clear empties the queue.
// Output channel: out_valid / out_stall with status, head_priority,
// head_payload, occupancy; one result beat per input beat, in order.
// Entries live in a circular buffer in one RAM, head pointer plus count.
// Clear, full, empty and unused codes go straight to the result; a remove
// first reads the head slot. An insert walks from the tail toward the head
// with one shared priority compare; for each moved entry it does a RAM read,
// then a compare and a write one slot up. The block takes one item at a
// time; in_stall drops on the edge that loads the result, and the next beat
// can be taken from then on.
// A result waits in the output register while out_stall is high; the next
// item can be taken meanwhile, but its result is held until the register
// frees. Reset empties the queue and drops any pending result.
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [PAYIN_W-1:0] payload,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [PRIO_W-1:0] head_priority,
  output logic [PAYIN_W-1:0] head_payload,
  output logic [CNT_W-1:0]  occupancy
);

  state_t state, state_next;

  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  hole, hole_next;
  logic [PRIO_W-1:0] prio_q, prio_q_next;
  logic [PAY_W-1:0]  pay_q, pay_q_next;

  logic [STAT_W-1:0] res_status, res_status_next;
  logic [PRIO_W-1:0] res_prio, res_prio_next;
  logic [PAY_W-1:0]  res_pay, res_pay_next;

  logic              accept;
  logic [CNT_W-1:0]  lidx;
  logic [CNT_W:0]    psum;
  logic [IDX_W-1:0]  addr;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [PRIO_W-1:0] rd_prio;
  logic [PAY_W-1:0]  rd_pay;
  logic              load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign rd_prio  = ram_rdata[WORD_W-1:PAY_W];
  assign rd_pay   = ram_rdata[PAY_W-1:0];
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // logical slot to physical RAM address, one wrap correction
  always_comb begin
    psum = (CNT_W + 1)'(head) + (CNT_W + 1)'(lidx);
    if (psum >= (CNT_W + 1)'(DEPTH)) begin
      psum = psum - (CNT_W + 1)'(DEPTH);
    end
    addr = psum[IDX_W-1:0];
  end

  spq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    hole       <= hole_next;
    prio_q     <= prio_q_next;
    pay_q      <= pay_q_next;
    res_status <= res_status_next;
    res_prio   <= res_prio_next;
    res_pay    <= res_pay_next;
  end

  // sequencer: next state, RAM access and result
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    hole_next       = hole;
    prio_q_next     = prio_q;
    pay_q_next      = pay_q;
    res_status_next = res_status;
    res_prio_next   = res_prio;
    res_pay_next    = res_pay;
    lidx            = '0;
    ram_we          = 1'b0;
    ram_wdata       = {prio_q, pay_q};

    case (state)
      S_IDLE: begin
        if (accept) begin
          prio_q_next     = priority_req;
          pay_q_next      = payload[PAY_W-1:0];
          res_status_next = ST_OK;
          res_prio_next   = '0;
          res_pay_next    = '0;
          hole_next       = count;
          state_next      = S_DONE;
          case (command)
            CMD_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                state_next = S_INS;
              end
            end
            CMD_REMOVE: begin
              // head slot read is issued now
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_REM;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        if (hole == '0) begin
          // reached the head, new entry goes first
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          state_next = S_DONE;
        end else begin
          lidx       = hole - 1'b1;
          state_next = S_CMP;
        end
      end

      S_CMP: begin
        lidx = hole;
        ram_we = 1'b1;
        if (rd_prio > prio_q) begin
          // stored entry is less urgent, move it one slot up
          ram_wdata  = ram_rdata;
          hole_next  = hole - 1'b1;
          state_next = S_INS;
        end else begin
          count_next = count + 1'b1;
          state_next = S_DONE;
        end
      end

      S_REM: begin
        res_prio_next = rd_prio;
        res_pay_next  = rd_pay;
        count_next    = count - 1'b1;
        if (head == IDX_W'(DEPTH - 1)) begin
          head_next = '0;
        end else begin
          head_next = head + 1'b1;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status        <= res_status;
      head_priority <= res_prio;
      head_payload  <= PAYIN_W'(res_pay);
      occupancy     <= count;
    end
  end

  // checks on queue bookkeeping
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_cmp_hole: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (hole != '0) && (hole <= count) && (count != CNT_W'(DEPTH)))
    else $error("insert walk outside occupied slots");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
    else $error("full status with free slots");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (head_priority == '0) && (head_payload == '0))
    else $error("error result carries an entry");

  a_remove_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |=> (count == $past(count) - 1'b1))
    else $error("remove did not drop one entry");

endmodule

@@ design/spq_ram.sv @@
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // cycles to linger after the last result: longest insert walk plus margin
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  typedef struct packed {
    logic [STAT_W-1:0]  st;
    logic [PRIO_W-1:0]  pr;
    logic [PAYIN_W-1:0] pay;
    logic [CNT_W-1:0]   occ;
  } q_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PRIO_W-1:0]  prio;
    logic [PAYIN_W-1:0] pay;
    logic [5:0]         reps;
    logic               typed;
    q_result_t          res;
  } dir_row_t;

  typedef struct packed {
    logic      typed;
    q_result_t res;
  } beat_note_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   command;
  logic [PRIO_W-1:0]  priority_req;
  logic [PAYIN_W-1:0] payload;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  status;
  logic [PRIO_W-1:0]  head_priority;
  logic [PAYIN_W-1:0] head_payload;
  logic [CNT_W-1:0]   occupancy;

  stable_priority_queue DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .priority_req  (priority_req),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .head_priority (head_priority),
    .head_payload  (head_payload),
    .occupancy     (occupancy)
  );

  // shadow copy of the sorted queue
  logic [PRIO_W-1:0] held_prio [DEPTH];
  logic [PAY_W-1:0]  held_pay  [DEPTH];
  int                held_count;

  q_result_t  pending_results [$];
  beat_note_t beat_notes [$];
  q_result_t  want;
  q_result_t  want_in;
  beat_note_t note_in;
  int         errors;
  int         send_idle_pct;
  int         stall_pct;

  // coverage tallies
  int n_insert, n_full, n_remove, n_empty, n_clear, n_unused, n_results, peak_occ;

  dir_row_t dir_tab [15];
  int       row, rep, phase, seg, n, pick, ins_bias, tie_base, wait_cyc;
  logic [CMD_W-1:0]  rnd_cmd;
  logic [PRIO_W-1:0] rnd_prio;

  // sorted insert after equal priorities, pop at head, clear
  function automatic q_result_t predict_queue_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [PRIO_W-1:0] pr,
                                                   input logic [PAYIN_W-1:0] pay);
    q_result_t r;
    int pos;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (held_count >= DEPTH) begin
          r.st = ST_FULL;
          n_full++;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] <= pr) pos++;
          for (int k = held_count; k > pos; k--) begin
            held_prio[k] = held_prio[k-1];
            held_pay[k]  = held_pay[k-1];
          end
          held_prio[pos] = pr;
          held_pay[pos]  = pay[PAY_W-1:0];
          held_count++;
          n_insert++;
          if (held_count > peak_occ) peak_occ = held_count;
        end
      end
      CMD_REMOVE: begin
        if (held_count == 0) begin
          r.st = ST_EMPTY;
          n_empty++;
        end else begin
          r.pr = held_prio[0];
          r.pay[PAY_W-1:0] = held_pay[0];
          for (int k = 1; k < held_count; k++) begin
            held_prio[k-1] = held_prio[k];
            held_pay[k-1]  = held_pay[k];
          end
          held_count--;
          n_remove++;
        end
      end
      CMD_CLEAR: begin
        held_count = 0;
        n_clear++;
      end
      default: n_unused++;
    endcase
    r.occ = held_count[CNT_W-1:0];
    return r;
  endfunction

  // one input beat, with random sender gaps ahead of it
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] pr,
                           input logic [PAYIN_W-1:0] pay, input logic typed,
                           input q_result_t typed_res);
    beat_note_t note;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    note.typed = typed;
    note.res   = typed_res;
    beat_notes = {beat_notes, note};
    in_valid     <= 1'b1;
    command      <= cmd;
    priority_req <= pr;
    payload      <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0 || beat_notes.size() != 0) @(negedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #10ms;
    $display("tb NOT OK");
    $finish;
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= !rst && stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  // accepted input beat: predict its result
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (beat_notes.size() != 0) note_in = beat_notes.pop_front();
      else note_in = '0;
      want_in = predict_queue_step(command, priority_req, payload);
      pending_results = {pending_results, (note_in.typed ? note_in.res : want_in)};
    end
  end

  // accepted result beat: compare with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (head_priority !== want.pr) begin
          $error("head_priority: expected %0d, got %0d", want.pr, head_priority);
          errors++;
        end
        if (head_payload !== want.pay) begin
          $error("head_payload: expected %h, got %h", want.pay, head_payload);
          errors++;
        end
        if (occupancy !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_INSERT;
    priority_req = '0;
    payload = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    held_count = 0;
    n_insert = 0; n_full = 0; n_remove = 0; n_empty = 0;
    n_clear = 0; n_unused = 0; n_results = 0; peak_occ = 0;

    // directed beats: empty queue, extremes, ties, fill to full
    dir_tab = '{
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000, 5'd0}},
      '{CMD_UNUSED, 3'd7, 16'hFFFF, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd0}},
      '{CMD_CLEAR,  3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd0}},
      '{CMD_INSERT, 3'd7, 16'hFFFF, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd1}},
      '{CMD_INSERT, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd2}},
      '{CMD_INSERT, 3'd7, 16'h0001, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd3}},
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd2}},
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd7, 16'hFFFF, 5'd1}},
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd7, 16'h0001, 5'd0}},
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000, 5'd0}},
      '{CMD_INSERT, 3'd7, 16'h5555, 6'(DEPTH), 1'b0, '0},
      '{CMD_INSERT, 3'd0, 16'hFFFF, 6'd1, 1'b1, '{ST_FULL, 3'd0, 16'h0000, 5'd16}},
      '{CMD_UNUSED, 3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd16}},
      '{CMD_REMOVE, 3'd0, 16'h0000, 6'd1, 1'b0, '0},
      '{CMD_CLEAR,  3'd0, 16'h0000, 6'd1, 1'b1, '{ST_OK, 3'd0, 16'h0000, 5'd0}}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // walk the table; repeated rows step priority down and payload up
    for (row = 0; row < 15; row++) begin
      for (rep = 0; rep < dir_tab[row].reps; rep++) begin
        send_beat(dir_tab[row].cmd, PRIO_W'(dir_tab[row].prio - rep),
                  PAYIN_W'(dir_tab[row].pay + rep), dir_tab[row].typed, dir_tab[row].res);
      end
    end
    drain_results();

    // random beats, one idling mode per phase
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      // segments alternate filling and draining; later ones crowd priorities for ties
      for (seg = 0; seg < 4; seg++) begin
        ins_bias = seg[0] ? 30 : 72;
        tie_base = $urandom_range(6);
        for (n = 0; n < 100; n++) begin
          pick = $urandom_range(99);
          if (pick == 0) rnd_cmd = CMD_CLEAR;
          else if (pick == 1) rnd_cmd = CMD_UNUSED;
          else if (pick < 2 + ins_bias) rnd_cmd = CMD_INSERT;
          else rnd_cmd = CMD_REMOVE;
          rnd_prio = seg[1] ? PRIO_W'(tie_base + $urandom_range(1)) : PRIO_W'($urandom_range(7));
          send_beat(rnd_cmd, rnd_prio, PAYIN_W'($urandom_range(16'hFFFF)), 1'b0, '0);
        end
      end
      drain_results();
    end

    // wind down
    in_valid <= 1'b0;
    for (wait_cyc = 0; pending_results.size() != 0 && wait_cyc < 100000; wait_cyc++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("run: %0d results; %0d inserts, %0d refused as full, %0d removes, %0d on empty",
             n_results, n_insert, n_full, n_remove, n_empty);
    $display("run: %0d clears, %0d unused codes, peak fill %0d, %0d mismatches",
             n_clear, n_unused, peak_occ, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
